// ===== hw/rtl/ptrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrt_pkg
// shared widths, codes and cell control types of the periodic task table
// ----------------------------------------------------------------------------
package ptrt_pkg;

   localparam int FUNC_W     = 2;
   localparam int SLOT_IN_W  = 4;
   localparam int SLOT_OUT_W = 5;
   localparam int TIME_W     = 16;
   localparam int RUN_W      = 32;
   localparam int KIND_W     = 2;
   localparam int CD_W       = 17;

   // results reported per tick, and a counter that can hold that number
   localparam int RES_MAX    = 16;
   localparam int RES_CNT_W  = 5;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TIME    = 2'd3;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic              shift;
      logic              report;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] mtime;
   } cell_ctl_type;

   // updated run statistics of a selected cell, zero when not selected
   typedef struct packed {
      logic [TIME_W-1:0] worst;
      logic [TIME_W-1:0] best;
      logic [RUN_W-1:0]  runs;
   } cell_stat_type;

endpackage

// ===== hw/rtl/ptrt_req_if.sv =====
// ----------------------------------------------------------------------------
// ptrt_req_if
// request channel of the periodic task table
// ----------------------------------------------------------------------------
interface ptrt_req_if;

   logic                             valid;
   logic                             ready;
   logic [ptrt_pkg::FUNC_W-1:0]      func;
   logic [ptrt_pkg::SLOT_IN_W-1:0]   slot;
   logic [ptrt_pkg::TIME_W-1:0]      first_delay;
   logic [ptrt_pkg::TIME_W-1:0]      task_period;
   logic [ptrt_pkg::TIME_W-1:0]      measured_time;

   modport source (
      output valid, func, slot, first_delay, task_period, measured_time,
      input  ready
   );

   modport sink (
      input  valid, func, slot, first_delay, task_period, measured_time,
      output ready
   );

endinterface

// ===== hw/rtl/ptrt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ptrt_rsp_if
// result channel of the periodic task table
// ----------------------------------------------------------------------------
interface ptrt_rsp_if;

   logic                              valid;
   logic                              ready;
   logic [ptrt_pkg::KIND_W-1:0]       kind;
   logic [ptrt_pkg::SLOT_OUT_W-1:0]   task_slot;
   logic                              accepted;
   logic [ptrt_pkg::TIME_W-1:0]       worst_time;
   logic [ptrt_pkg::TIME_W-1:0]       best_time;
   logic [ptrt_pkg::RUN_W-1:0]        run_count;
   logic                              last;

   modport source (
      output valid, kind, task_slot, accepted, worst_time, best_time, run_count, last,
      input  ready
   );

   modport sink (
      input  valid, kind, task_slot, accepted, worst_time, best_time, run_count, last,
      output ready
   );

endinterface

// ===== hw/rtl/ptrt_cell.sv =====
// ----------------------------------------------------------------------------
// ptrt_cell
// one task slot: countdown, reload period, run statistics and scan token
// ----------------------------------------------------------------------------
module ptrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ptrt_pkg::cell_ctl_type ctl,
   input  logic                   add_sel,
   input  logic                   rpt_sel,
   input  logic                   tok_in,
   output logic                   tok_out,
   output logic                   rel,
   output ptrt_pkg::cell_stat_type stat
);

   logic                          tok_ff, tok_in_nx;
   logic                          valid_ff, valid_in;
   logic [ptrt_pkg::CD_W-1:0]     cd_ff, cd_in;
   logic [ptrt_pkg::TIME_W-1:0]   period_ff, period_in;
   logic [ptrt_pkg::TIME_W-1:0]   worst_ff, worst_in;
   logic [ptrt_pkg::TIME_W-1:0]   best_ff, best_in;
   logic [ptrt_pkg::RUN_W-1:0]    runs_ff, runs_in;
   ptrt_pkg::cell_stat_type       upd;
   logic                          hit;

   // countdown reaches zero on this step
   assign hit = tok_ff && valid_ff && (cd_ff == ptrt_pkg::CD_W'(1));
   assign rel = hit;
   assign tok_out = tok_ff;

   always_comb begin
      upd.worst = (ctl.mtime > worst_ff) ? ctl.mtime : worst_ff;
      upd.best  = (ctl.mtime < best_ff) ? ctl.mtime : best_ff;
      upd.runs  = runs_ff + ptrt_pkg::RUN_W'(1);
      stat      = rpt_sel ? upd : '0;
   end

   always_comb begin
      tok_in_nx = ctl.shift ? tok_in : tok_ff;
      valid_in  = valid_ff;
      cd_in     = cd_ff;
      period_in = period_ff;
      worst_in  = worst_ff;
      best_in   = best_ff;
      runs_in   = runs_ff;
      if (add_sel) begin
         valid_in  = 1'b1;
         cd_in     = ptrt_pkg::CD_W'(ctl.delay) + ptrt_pkg::CD_W'(1);
         period_in = ctl.period;
      end else if (ctl.shift && tok_ff && valid_ff) begin
         cd_in = hit ? ptrt_pkg::CD_W'(period_ff) : cd_ff - ptrt_pkg::CD_W'(1);
      end
      if (ctl.report && rpt_sel) begin
         worst_in = upd.worst;
         best_in  = upd.best;
         runs_in  = upd.runs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 1'b0;
         valid_ff <= 1'b0;
         worst_ff <= '0;
         best_ff  <= '1;
         runs_ff  <= '0;
      end else begin
         tok_ff   <= tok_in_nx;
         valid_ff <= valid_in;
         worst_ff <= worst_in;
         best_ff  <= best_in;
         runs_ff  <= runs_in;
      end
   end

   // task timing is only read once the slot was written by an add
   always_ff @(posedge clock) begin
      cd_ff     <= cd_in;
      period_ff <= period_in;
   end

endmodule

// ===== hw/rtl/periodic_task_release_table.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_table
// add and report: an accepted item moves to S_ADD or S_RPT, then loads the result
// register once it is free; tick: a scan token walks the cell chain one slot per
// cycle while the result side does not stall, then S_FIN writes the closing result
// one item at a time; synchronous reset clears the table, count and statistics
// ----------------------------------------------------------------------------
module periodic_task_release_table #(
   parameter int MAX_TASKS = 16
) (
   input  logic         clock,
   input  logic         reset,
   ptrt_req_if.sink     req,
   ptrt_rsp_if.source   rsp
);

   // task count has to hold MAX_TASKS itself, the scan index only the slots
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_TICK,
      S_FIN,
      S_RPT
   } state_type;

   state_type                           state_ff, state_in;

   // latched request fields
   logic [ptrt_pkg::SLOT_IN_W-1:0]      slot_ff, slot_in;
   logic [ptrt_pkg::TIME_W-1:0]         delay_ff, delay_in;
   logic [ptrt_pkg::TIME_W-1:0]         period_ff, period_in;
   logic [ptrt_pkg::TIME_W-1:0]         mtime_ff, mtime_in;

   // table bookkeeping and tick scan
   logic [CW-1:0]                       count_ff, count_in;
   logic [IW-1:0]                       idx_ff, idx_in;
   logic [ptrt_pkg::RES_CNT_W-1:0]      rel_cnt_ff, rel_cnt_in;
   logic                                pend_v_ff, pend_v_in;
   logic [ptrt_pkg::SLOT_OUT_W-1:0]     pend_slot_ff, pend_slot_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ptrt_pkg::KIND_W-1:0]         kind_ff, kind_in;
   logic [ptrt_pkg::SLOT_OUT_W-1:0]     tslot_ff, tslot_in;
   logic                                acc_ff, acc_in;
   logic [ptrt_pkg::TIME_W-1:0]         worst_ff, worst_in;
   logic [ptrt_pkg::TIME_W-1:0]         best_ff, best_in;
   logic [ptrt_pkg::RUN_W-1:0]          runs_ff, runs_in;
   logic                                last_ff, last_in;

   // cell chain
   ptrt_pkg::cell_ctl_type              ctl;
   ptrt_pkg::cell_stat_type             stat_arr [MAX_TASKS];
   ptrt_pkg::cell_stat_type             stat_any;
   logic [MAX_TASKS-1:0]                tok_vec;
   logic [MAX_TASKS-1:0]                rel_vec;
   logic [MAX_TASKS-1:0]                add_sel;
   logic [MAX_TASKS-1:0]                rpt_sel;

   logic                                out_free;
   logic                                accept;
   logic                                load;
   logic                                step;
   logic                                add_ok;
   logic                                add_en;
   logic                                rel_take;

   // result register frees up when empty or taken this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign accept = req.valid && req.ready;

   // a tick seeds the token into slot 0; each step moves it one cell on
   assign load = accept && (req.func == ptrt_pkg::FUNC_TICK);
   assign step = (state_ff == S_TICK) && out_free;

   assign add_ok = (count_ff < CW'(MAX_TASKS)) && (period_ff != '0);
   assign add_en = (state_ff == S_ADD) && out_free && add_ok;

   // only the first RES_MAX releases of a tick are reported
   assign rel_take = step && (|rel_vec) &&
                     (rel_cnt_ff < ptrt_pkg::RES_CNT_W'(ptrt_pkg::RES_MAX));

   always_comb begin
      ctl.shift  = load || step;
      ctl.report = (state_ff == S_RPT) && out_free;
      ctl.delay  = delay_ff;
      ctl.period = period_ff;
      ctl.mtime  = mtime_ff;
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      logic tok_prev;

      if (i == 0) begin : g_head
         assign tok_prev = load;
      end else begin : g_link
         assign tok_prev = tok_vec[i-1];
      end

      // new task goes to the next free slot
      assign add_sel[i] = add_en && (count_ff == CW'(i));
      // reports for slots past the table select no cell and read as zero
      assign rpt_sel[i] = (32'(slot_ff) == 32'(i));

      ptrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .add_sel (add_sel[i]),
         .rpt_sel (rpt_sel[i]),
         .tok_in  (tok_prev),
         .tok_out (tok_vec[i]),
         .rel     (rel_vec[i]),
         .stat    (stat_arr[i])
      );
   end

   // at most one cell drives nonzero statistics
   always_comb begin
      stat_any = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         stat_any = stat_any | stat_arr[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      delay_in     = delay_ff;
      period_in    = period_ff;
      mtime_in     = mtime_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rel_cnt_in   = rel_cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      tslot_in     = tslot_ff;
      acc_in       = acc_ff;
      worst_in     = worst_ff;
      best_in      = best_ff;
      runs_in      = runs_ff;
      last_in      = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               slot_in   = req.slot;
               delay_in  = req.first_delay;
               period_in = req.task_period;
               mtime_in  = req.measured_time;
               unique case (req.func)
                  ptrt_pkg::FUNC_ADD: begin
                     state_in = S_ADD;
                  end
                  ptrt_pkg::FUNC_TICK: begin
                     state_in   = S_TICK;
                     idx_in     = '0;
                     rel_cnt_in = '0;
                     pend_v_in  = 1'b0;
                  end
                  ptrt_pkg::FUNC_REPORT: begin
                     state_in = S_RPT;
                  end
                  default: begin
                     // unused code: dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_ADD: begin
            if (out_free) begin
               count_in     = count_ff + CW'(add_ok);
               rsp_valid_in = 1'b1;
               kind_in      = ptrt_pkg::KIND_ADD;
               tslot_in     = ptrt_pkg::SLOT_OUT_W'(count_ff + CW'(add_ok));
               acc_in       = add_ok;
               worst_in     = '0;
               best_in      = '0;
               runs_in      = '0;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_TICK: begin
            if (step) begin
               if (rel_take) begin
                  // hold each release back until the next one or the scan end so the final one gets last
                  rel_cnt_in   = rel_cnt_ff + ptrt_pkg::RES_CNT_W'(1);
                  pend_v_in    = 1'b1;
                  pend_slot_in = ptrt_pkg::SLOT_OUT_W'(idx_ff);
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     kind_in      = ptrt_pkg::KIND_RELEASE;
                     tslot_in     = pend_slot_ff;
                     acc_in       = 1'b0;
                     worst_in     = '0;
                     best_in      = '0;
                     runs_in      = '0;
                     last_in      = 1'b0;
                  end
               end
               if (idx_ff == IW'(MAX_TASKS - 1)) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = pend_v_ff ? ptrt_pkg::KIND_RELEASE : ptrt_pkg::KIND_NONE;
               tslot_in     = pend_v_ff ? pend_slot_ff : '0;
               acc_in       = 1'b0;
               worst_in     = '0;
               best_in      = '0;
               runs_in      = '0;
               last_in      = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end

         S_RPT: begin
            // cells write back their statistics in the same cycle
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = ptrt_pkg::KIND_TIME;
               tslot_in     = ptrt_pkg::SLOT_OUT_W'(slot_ff);
               acc_in       = 1'b0;
               worst_in     = stat_any.worst;
               best_in      = stat_any.best;
               runs_in      = stat_any.runs;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rel_cnt_ff   <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rel_cnt_ff   <= rel_cnt_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      delay_ff     <= delay_in;
      period_ff    <= period_in;
      mtime_ff     <= mtime_in;
      pend_slot_ff <= pend_slot_in;
      kind_ff      <= kind_in;
      tslot_ff     <= tslot_in;
      acc_ff       <= acc_in;
      worst_ff     <= worst_in;
      best_ff      <= best_in;
      runs_ff      <= runs_in;
      last_ff      <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = kind_ff;
   assign rsp.task_slot  = tslot_ff;
   assign rsp.accepted   = acc_ff;
   assign rsp.worst_time = worst_ff;
   assign rsp.best_time  = best_ff;
   assign rsp.run_count  = runs_ff;
   assign rsp.last       = last_ff;

   // the scan token is never in two cells at once
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("scan token duplicated");

   // while scanning, the token sits in the cell the index points at
   a_tok_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK) |-> tok_vec[idx_ff])
      else $error("scan token and index disagree");

   // the token has left the chain once the tick is finishing
   a_tok_gone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (tok_vec == '0))
      else $error("scan token left behind");

   // task count never runs past the table
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count overflow");

endmodule

// ===== dv/periodic_task_release_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_release_table_tb
// self-checking bench for the periodic task table: directed add, tick and
// run-time report items, then a random mix, all checked against a cycle-free
// model of the table under random valid and ready stalls
// ----------------------------------------------------------------------------
module periodic_task_release_table_tb;

   // table size of the instance, and the request code that has no function
   localparam int                          TABLE_SIZE    = 16;
   localparam logic [ptrt_pkg::FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
   localparam int                          RANDOM_ITEMS  = 190;
   // a tick walks every slot once; leave room for a stalled result side
   localparam int                          SETTLE_CYCLES = 2 * (TABLE_SIZE + 2) + 8;
   localparam int                          CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [ptrt_pkg::FUNC_W-1:0]    func;
      logic [ptrt_pkg::SLOT_IN_W-1:0] slot;
      logic [ptrt_pkg::TIME_W-1:0]    first_delay;
      logic [ptrt_pkg::TIME_W-1:0]    task_period;
      logic [ptrt_pkg::TIME_W-1:0]    measured_time;
   } table_req_type;

   typedef struct packed {
      logic [ptrt_pkg::KIND_W-1:0]     kind;
      logic [ptrt_pkg::SLOT_OUT_W-1:0] task_slot;
      logic                            accepted;
      logic [ptrt_pkg::TIME_W-1:0]     worst_time;
      logic [ptrt_pkg::TIME_W-1:0]     best_time;
      logic [ptrt_pkg::RUN_W-1:0]      run_count;
      logic                            last;
   } table_rsp_type;

   logic clock;
   logic reset;

   // idling on both sides is switched off while this is high
   logic steady;

   ptrt_req_if req_if ();
   ptrt_rsp_if rsp_if ();

   periodic_task_release_table #(
      .MAX_TASKS (TABLE_SIZE)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // ------------------------------------------------------------------------
   // table model: its own copy of the slots, countdowns and statistics
   // ------------------------------------------------------------------------
   logic                            task_live   [TABLE_SIZE] = '{default: 1'b0};
   logic [ptrt_pkg::CD_W-1:0]       task_left   [TABLE_SIZE] = '{default: '0};
   logic [ptrt_pkg::TIME_W-1:0]     task_reload [TABLE_SIZE] = '{default: '0};
   logic [ptrt_pkg::SLOT_OUT_W-1:0] tasks_held = '0;
   logic [ptrt_pkg::TIME_W-1:0]     slot_worst  [TABLE_SIZE] = '{default: '0};
   logic [ptrt_pkg::TIME_W-1:0]     slot_best   [TABLE_SIZE] = '{default: '1};
   logic [ptrt_pkg::RUN_W-1:0]      slot_runs   [TABLE_SIZE] = '{default: '0};

   // results still owed by the block, oldest first
   table_rsp_type awaited_results [$];

   int mismatches    = 0;
   int adds_sent     = 0;
   int adds_stored   = 0;
   int ticks_sent    = 0;
   int releases_due  = 0;
   int widest_burst  = 0;
   int idle_ticks    = 0;
   int reports_sent  = 0;
   int ignored_sent  = 0;
   int cycle_count   = 0;

   // advance the table model by one accepted item and queue what it owes
   function automatic void predict_table_step(input table_req_type it);
      table_rsp_type r;
      table_rsp_type burst [$];
      int            i;

      r      = '0;
      r.last = 1'b1;
      case (it.func)
         ptrt_pkg::FUNC_ADD: begin
            adds_sent++;
            // stored only while a slot is free and the period is nonzero
            if (tasks_held < TABLE_SIZE && it.task_period != '0) begin
               task_live[tasks_held]   = 1'b1;
               task_left[tasks_held]   = {1'b0, it.first_delay} + 1'b1;
               task_reload[tasks_held] = it.task_period;
               tasks_held              = tasks_held + 1'b1;
               r.accepted              = 1'b1;
               adds_stored++;
            end
            r.kind      = ptrt_pkg::KIND_ADD;
            r.task_slot = tasks_held;
            awaited_results.push_back(r);
         end
         ptrt_pkg::FUNC_TICK: begin
            ticks_sent++;
            for (i = 0; i < TABLE_SIZE; i++) begin
               if (task_live[i]) begin
                  task_left[i] = task_left[i] - 1'b1;
                  if (task_left[i] == '0) begin
                     task_left[i] = {1'b0, task_reload[i]};
                     // reload always, report only while there is room
                     if (burst.size() < ptrt_pkg::RES_MAX) begin
                        r           = '0;
                        r.kind      = ptrt_pkg::KIND_RELEASE;
                        r.task_slot = ptrt_pkg::SLOT_OUT_W'(i);
                        burst.push_back(r);
                     end
                  end
               end
            end
            if (burst.size() == 0) begin
               // nothing due: one empty answer closes the tick
               r      = '0;
               r.kind = ptrt_pkg::KIND_NONE;
               r.last = 1'b1;
               awaited_results.push_back(r);
               idle_ticks++;
            end else begin
               r      = burst.pop_back();
               r.last = 1'b1;
               burst.push_back(r);
               releases_due += burst.size();
               if (burst.size() > widest_burst) widest_burst = burst.size();
               foreach (burst[k]) awaited_results.push_back(burst[k]);
            end
         end
         ptrt_pkg::FUNC_REPORT: begin
            reports_sent++;
            r.kind      = ptrt_pkg::KIND_TIME;
            r.task_slot = {1'b0, it.slot};
            // slots beyond the table are answered with zero statistics
            if (it.slot < TABLE_SIZE) begin
               slot_runs[it.slot] = slot_runs[it.slot] + 1'b1;
               if (it.measured_time > slot_worst[it.slot])
                  slot_worst[it.slot] = it.measured_time;
               if (it.measured_time < slot_best[it.slot])
                  slot_best[it.slot] = it.measured_time;
               r.worst_time = slot_worst[it.slot];
               r.best_time  = slot_best[it.slot];
               r.run_count  = slot_runs[it.slot];
            end
            awaited_results.push_back(r);
         end
         default: begin
            // unused code: the block drops the item without an answer
            ignored_sent++;
         end
      endcase
   endfunction

   function automatic table_req_type make_item(
         input logic [ptrt_pkg::FUNC_W-1:0]    func,
         input logic [ptrt_pkg::SLOT_IN_W-1:0] slot,
         input logic [ptrt_pkg::TIME_W-1:0]    delay,
         input logic [ptrt_pkg::TIME_W-1:0]    period,
         input logic [ptrt_pkg::TIME_W-1:0]    mtime);
      table_req_type it;
      it.func          = func;
      it.slot          = slot;
      it.first_delay   = delay;
      it.task_period   = period;
      it.measured_time = mtime;
      return it;
   endfunction

   // random field values at the field widths
   function automatic logic [ptrt_pkg::SLOT_IN_W-1:0] rand_slot();
      return ptrt_pkg::SLOT_IN_W'($urandom_range(15));
   endfunction

   function automatic logic [ptrt_pkg::TIME_W-1:0] rand_time();
      return ptrt_pkg::TIME_W'($urandom_range(65535));
   endfunction

   // ------------------------------------------------------------------------
   // clock, timeout and the result side
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // compare every accepted result with the oldest one owed
   function automatic void check_result(input table_rsp_type got);
      table_rsp_type want;

      if (awaited_results.size() == 0) begin
         $error("unexpected result: kind %0d task_slot %0d", got.kind, got.task_slot);
         mismatches++;
         return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         mismatches++;
      end
      if (got.task_slot !== want.task_slot) begin
         $error("task_slot: expected %0d, got %0d", want.task_slot, got.task_slot);
         mismatches++;
      end
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
         mismatches++;
      end
      if (got.worst_time !== want.worst_time) begin
         $error("worst_time: expected %0d, got %0d", want.worst_time, got.worst_time);
         mismatches++;
      end
      if (got.best_time !== want.best_time) begin
         $error("best_time: expected %0d, got %0d", want.best_time, got.best_time);
         mismatches++;
      end
      if (got.run_count !== want.run_count) begin
         $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         mismatches++;
      end
   endfunction

   // sample the handshake as it stood at the edge, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         check_result('{kind:       rsp_if.kind,
                        task_slot:  rsp_if.task_slot,
                        accepted:   rsp_if.accepted,
                        worst_time: rsp_if.worst_time,
                        best_time:  rsp_if.best_time,
                        run_count:  rsp_if.run_count,
                        last:       rsp_if.last});
      end
      // stall with a chance of about 18 in a hundred unless in the steady stretch
      rsp_if.ready <= steady || ($urandom_range(99) >= 18);
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one item, holding it until the block takes it; valid stays high
   // after the accept so back-to-back items need no extra assignment
   task automatic send_item(input table_req_type it);
      if (!steady && $urandom_range(99) < 18) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= it.func;
      req_if.slot          <= it.slot;
      req_if.first_delay   <= it.first_delay;
      req_if.task_period   <= it.task_period;
      req_if.measured_time <= it.measured_time;
      do @(posedge clock); while (!req_if.ready);
      predict_table_step(it);
   endtask

   // hold off the sender until the block owes nothing
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // zero-period add on an empty table, and a tick with nothing to release
   task automatic test_empty_table();
      send_item(make_item(ptrt_pkg::FUNC_ADD, 4'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(ptrt_pkg::FUNC_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
   endtask

   // run-time statistics on slots that hold no task yet: extremes, a new
   // best below the first value and a new worst above it, unused code
   task automatic test_time_records();
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd0,  16'd0, 16'd0, 16'd0));
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd15, 16'd0, 16'd0, 16'hFFFF));
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd9,  16'd0, 16'd0, 16'h1234));
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd9,  16'd0, 16'd0, 16'h00FF));
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd9,  16'd0, 16'd0, 16'hF00D));
      send_item(make_item(FUNC_UNUSED,           4'd5,  16'hA5A5, 16'h5A5A, 16'h0F0F));
      send_item(make_item(ptrt_pkg::FUNC_REPORT, 4'd0,  16'd0, 16'd0, 16'h8000));
   endtask

   // fill all slots before any real tick; each period divides 12 and each
   // first release lands on a multiple of it, so from tick 36 on every
   // twelfth tick releases all sixteen tasks at once
   task automatic test_fill_table();
      logic [ptrt_pkg::TIME_W-1:0] periods [6] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd6,
                                                  16'd12};
      logic [ptrt_pkg::TIME_W-1:0] p;
      int                          n;

      // first release on the very next tick
      send_item(make_item(ptrt_pkg::FUNC_ADD, rand_slot(), 16'd0, 16'd1, rand_time()));
      for (n = 1; n < TABLE_SIZE; n++) begin
         if (n == 8) begin
            // zero period with tasks present: count comes back unchanged
            send_item(make_item(ptrt_pkg::FUNC_ADD, rand_slot(), rand_time(),
                                16'd0, rand_time()));
         end
         p = periods[$urandom_range(5)];
         send_item(make_item(ptrt_pkg::FUNC_ADD, rand_slot(),
                             ptrt_pkg::TIME_W'(p * $urandom_range(3, 1) - 1),
                             p, rand_time()));
      end
      // table full: rejected even with all-ones fields
      send_item(make_item(ptrt_pkg::FUNC_ADD, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
   endtask

   // random mix of ticks, reports, unused codes and (now always rejected) adds,
   // with a stretch of back-to-back traffic and a pause for the block to drain
   task automatic test_random_mix();
      table_req_type               it;
      int                          counted;
      int                          pick;
      logic [ptrt_pkg::TIME_W-1:0] mtime;

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted == 60) steady <= 1'b1;
         if (counted == 120) steady <= 1'b0;
         if (counted == 160 && awaited_results.size() != 0)
            wait_drained();

         case ($urandom_range(3))
            0:       mtime = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1:       mtime = ptrt_pkg::TIME_W'($urandom_range(255));
            default: mtime = rand_time();
         endcase
         it = make_item(ptrt_pkg::FUNC_TICK, rand_slot(), rand_time(), rand_time(), mtime);
         pick = $urandom_range(99);
         if (pick < 40) begin
            it.func = ptrt_pkg::FUNC_TICK;
         end else if (pick < 80) begin
            it.func = ptrt_pkg::FUNC_REPORT;
         end else if (pick < 92) begin
            it.func = ptrt_pkg::FUNC_ADD;
            if ($urandom_range(3) == 0) it.task_period = '0;
         end else begin
            it.func = FUNC_UNUSED;
         end
         send_item(it);
         if (it.func != FUNC_UNUSED) counted++;
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      steady               = 1'b0;
      req_if.valid         = 1'b0;
      req_if.func          = ptrt_pkg::FUNC_ADD;
      req_if.slot          = '0;
      req_if.first_delay   = '0;
      req_if.task_period   = '0;
      req_if.measured_time = '0;
      rsp_if.ready         = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_time_records();
      test_fill_table();
      // let the directed part settle before random traffic starts
      wait_drained();
      test_random_mix();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d adds (%0d stored), %0d ticks, %0d releases, widest burst %0d",
               adds_sent, adds_stored, ticks_sent, releases_due, widest_burst);
      $display("     %0d empty ticks, %0d time reports, %0d unused-code items, %0d errors",
               idle_ticks, reports_sent, ignored_sent, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
